// File: rtl/core/lne_pkg.sv
// Package for the keystroke line editor: line capacity, key codes,
// count width, stack control struct and controller state type.
// No dependencies.
`default_nettype none

package lne_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);

  localparam logic [7:0] KEY_LEFT    = 8'd60;
  localparam logic [7:0] KEY_RIGHT   = 8'd62;
  localparam logic [7:0] KEY_DELETE  = 8'd45;
  localparam logic [7:0] KEY_NEWLINE = 8'd10;

  // push: every cell takes its lower neighbor, cell 0 takes push data
  // pop:  every cell takes its upper neighbor
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  typedef enum logic [2:0] {
    ST_EDIT = 3'b001,
    ST_MOVE = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/lne_cell.sv
// One character cell of a stack chain.
// Depends on lne_pkg for the stack control struct.
`default_nettype none

module lne_cell (
  input  wire               clk,
  input  lne_pkg::stack_op_t op,
  input  wire  [7:0]        from_below,
  input  wire  [7:0]        from_above,
  output logic [7:0]        data
);
  import lne_pkg::*;

  always_ff @(posedge clk) begin
    if (op.push) begin
      data <= from_below;
    end else if (op.pop) begin
      data <= from_above;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lne_stack.sv
// Stack built as a row of lne_cell; the top of stack is always cell 0.
// Depends on lne_pkg and lne_cell.
`default_nettype none

module lne_stack (
  input  wire               clk,
  input  lne_pkg::stack_op_t op,
  input  wire  [7:0]        push_data,
  output logic [7:0]        top_data
);
  import lne_pkg::*;

  logic [7:0] cell_q [LINE_CAPACITY];

  for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
    logic [7:0] below;
    logic [7:0] above;

    if (i == 0) begin : g_first
      assign below = push_data;
    end else begin : g_inner_b
      assign below = cell_q[i-1];
    end

    // nothing above the last cell; a pop leaves it as don't-care
    if (i == LINE_CAPACITY - 1) begin : g_last
      assign above = 8'h00;
    end else begin : g_inner_a
      assign above = cell_q[i+1];
    end

    lne_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_below (below),
      .from_above (above),
      .data       (cell_q[i])
    );
  end

  assign top_data = cell_q[0];

endmodule

`default_nettype wire

// File: rtl/core/keystroke_line_editor.sv
// Top level of the keystroke line editor: two cell-chain stacks and the
// edit/drain controller. Depends on lne_pkg and lne_stack.
`default_nettype none

// Usage: a key request is taken at a clock edge with start high and busy
// low. Cursor moves, deletes and inserts leave busy low, so keys may
// arrive every cycle. A newline on an empty line gives its single result
// in the next cycle and leaves busy low. A newline on a non-empty line
// holds busy high while the line is shifted and drained. The left chain
// first shifts into the right chain one character per cycle, starting in
// the newline cycle itself. The right chain then shifts out one character
// per cycle. Each character is shown for one cycle with out_valid high, in
// the cycle after its shift, so the last result shows in the cycle after
// busy falls. Results cannot be stalled; the receiver must take one on
// every cycle that out_valid is high. last_of_line marks the final result.
module keystroke_line_editor (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire  [7:0] key_byte,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic       line_empty,
  output logic       last_of_line,
  output logic       overflowed
);
  import lne_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  state_t           state;
  logic [CNT_W-1:0] left_count;
  logic [CNT_W-1:0] right_count;
  logic             overflow_seen;

  stack_op_t  left_op, right_op;
  logic [7:0] left_push, left_top, right_top;
  logic [CNT_W-1:0] total;
  logic       accept;

  assign busy   = (state != ST_EDIT);
  assign accept = start && !busy;
  assign total  = left_count + right_count;

  always_comb begin
    left_op   = '0;
    right_op  = '0;
    left_push = key_byte;
    if (state == ST_MOVE) begin
      left_op.pop   = 1'b1;
      right_op.push = 1'b1;
    end else if (state == ST_EMIT) begin
      right_op.pop = 1'b1;
    end else if (accept) begin
      case (key_byte)
        KEY_NEWLINE: begin
          if (left_count != '0) begin
            left_op.pop   = 1'b1;
            right_op.push = 1'b1;
          end
        end
        KEY_LEFT: begin
          if (left_count != '0 && right_count < CAP) begin
            left_op.pop   = 1'b1;
            right_op.push = 1'b1;
          end
        end
        KEY_RIGHT: begin
          if (right_count != '0 && left_count < CAP) begin
            right_op.pop  = 1'b1;
            left_op.push  = 1'b1;
            left_push     = right_top;
          end
        end
        KEY_DELETE: begin
          if (left_count != '0) begin
            left_op.pop = 1'b1;
          end
        end
        default: begin
          if (total < CAP) begin
            left_op.push = 1'b1;
          end
        end
      endcase
    end
  end

  lne_stack u_left (
    .clk       (clk),
    .op        (left_op),
    .push_data (left_push),
    .top_data  (left_top)
  );

  lne_stack u_right (
    .clk       (clk),
    .op        (right_op),
    .push_data (left_top),
    .top_data  (right_top)
  );

  // counters and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_EDIT;
      left_count    <= '0;
      right_count   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (left_op.push) left_count <= left_count + ONE;
      if (left_op.pop)  left_count <= left_count - ONE;
      if (right_op.push && !right_op.pop) right_count <= right_count + ONE;
      if (right_op.pop && !right_op.push) right_count <= right_count - ONE;

      case (state)
        ST_EDIT: begin
          if (accept) begin
            case (key_byte)
              KEY_NEWLINE: begin
                if (total == '0) begin
                  out_valid     <= 1'b1;
                  overflow_seen <= 1'b0;
                end else if (left_count != '0) begin
                  state <= (left_count == ONE) ? ST_EMIT : ST_MOVE;
                end else begin
                  state <= ST_EMIT;
                end
              end
              KEY_LEFT, KEY_RIGHT, KEY_DELETE: begin
              end
              default: begin
                if (total >= CAP) overflow_seen <= 1'b1;
              end
            endcase
          end
        end
        ST_MOVE: begin
          if (left_count == ONE) state <= ST_EMIT;
        end
        ST_EMIT: begin
          out_valid <= 1'b1;
          if (right_count == ONE) begin
            state         <= ST_EDIT;
            overflow_seen <= 1'b0;
          end
        end
        default: state <= ST_EDIT;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      out_char     <= right_top;
      line_empty   <= 1'b0;
      last_of_line <= (right_count == ONE);
      overflowed   <= overflow_seen;
    end else begin
      out_char     <= 8'h00;
      line_empty   <= 1'b1;
      last_of_line <= 1'b1;
      overflowed   <= overflow_seen;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, left_count} + {1'b0, right_count}) <= {1'b0, CAP})
    else $error("line holds more characters than its capacity");

  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE) |-> (left_count != '0))
    else $error("left chain shift with empty left stack");

  a_emit_left_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (left_count == '0 && right_count != '0))
    else $error("drain entered with left stack not empty");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_line) |-> (left_count == '0 && right_count == '0
      && state == ST_EDIT))
    else $error("line end left characters behind");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_empty) |-> (last_of_line && out_char == 8'h00))
    else $error("empty line result malformed");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for keystroke_line_editor: random and directed keystrokes with
// a two-stack line tracker that predicts every emitted character.
// Depends on lne_pkg and the keystroke_line_editor RTL.
`default_nettype none

module tb_top;
  import lne_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_STOP = 350;

  // empty line, ignored edits at both ends, extreme bytes, delete, moves
  localparam logic [7:0] DIRECTED_KEYS [22] = '{
    KEY_NEWLINE, KEY_LEFT, KEY_RIGHT, KEY_DELETE, KEY_NEWLINE,
    8'h00, 8'hFF, 8'h0D, 8'h61, KEY_LEFT, KEY_LEFT, KEY_DELETE, KEY_RIGHT,
    8'h80, 8'h7F, KEY_RIGHT, KEY_RIGHT, KEY_NEWLINE,
    8'h55, 8'hAA, KEY_LEFT, KEY_NEWLINE
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       empty;
    logic       last;
    logic       ovf;
  } line_char_t;

  class line_tracker;
    logic [7:0] left_chars [LINE_CAPACITY];
    logic [7:0] right_chars [LINE_CAPACITY];
    int         left_n;
    int         right_n;
    logic       ovf_seen;
    line_char_t expected_chars [$];
    int         errors;
    int         lines_done;
    int         ovf_lines;
    int         empty_lines;
    int         chars_checked;

    function new();
      left_n = 0;
      right_n = 0;
      ovf_seen = 1'b0;
      errors = 0;
      lines_done = 0;
      ovf_lines = 0;
      empty_lines = 0;
      chars_checked = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void take_key(logic [7:0] k);
      line_char_t c;
      int         total;
      int         n;
      if (k == KEY_NEWLINE) begin
        total = left_n + right_n;
        lines_done++;
        if (ovf_seen) ovf_lines++;
        if (total == 0) begin
          empty_lines++;
          c = '{ch: 8'h00, empty: 1'b1, last: 1'b1, ovf: ovf_seen};
          expected_chars.push_back(c);
        end else begin
          n = 0;
          for (int i = 0; i < left_n; i++) begin
            n++;
            c = '{ch: left_chars[i], empty: 1'b0, last: (n == total), ovf: ovf_seen};
            expected_chars.push_back(c);
          end
          for (int i = right_n; i > 0; i--) begin
            n++;
            c = '{ch: right_chars[i-1], empty: 1'b0, last: (n == total), ovf: ovf_seen};
            expected_chars.push_back(c);
          end
        end
        left_n = 0;
        right_n = 0;
        ovf_seen = 1'b0;
      end else if (k == KEY_LEFT) begin
        if (left_n > 0 && right_n < LINE_CAPACITY) begin
          left_n--;
          right_chars[right_n] = left_chars[left_n];
          right_n++;
        end
      end else if (k == KEY_RIGHT) begin
        if (right_n > 0 && left_n < LINE_CAPACITY) begin
          right_n--;
          left_chars[left_n] = right_chars[right_n];
          left_n++;
        end
      end else if (k == KEY_DELETE) begin
        if (left_n > 0) left_n--;
      end else if (left_n + right_n < LINE_CAPACITY) begin
        left_chars[left_n] = k;
        left_n++;
      end else begin
        ovf_seen = 1'b1;
      end
    endfunction

    function void check_char(line_char_t got);
      line_char_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_char=%0d line_empty=%0b", got.ch, got.empty);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (got.ch !== want.ch) begin
        $error("out_char: expected %0d, got %0d", want.ch, got.ch);
        errors++;
      end
      if (got.empty !== want.empty) begin
        $error("line_empty: expected %0b, got %0b", want.empty, got.empty);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_line: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $error("overflowed: expected %0b, got %0b", want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] key_byte = 8'h00;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_char;
  logic       line_empty;
  logic       last_of_line;
  logic       overflowed;

  line_tracker tracker = new();
  int          keys_sent = 0;

  keystroke_line_editor dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .key_byte     (key_byte),
    .out_valid    (out_valid),
    .out_char     (out_char),
    .line_empty   (line_empty),
    .last_of_line (last_of_line),
    .overflowed   (overflowed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid)
      tracker.check_char('{ch: out_char, empty: line_empty, last: last_of_line,
                           ovf: overflowed});
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // start stays high if the next request follows directly
  task automatic send_key(input logic [7:0] k);
    start <= 1'b1;
    key_byte <= k;
    do @(posedge clk); while (busy);
    tracker.take_key(k);
    keys_sent++;
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic key_with_gaps(input logic [7:0] k);
    // keys 150..229 go back to back
    if ((keys_sent < 150 || keys_sent >= 230) && $urandom_range(99) < 19)
      pause($urandom_range(1, 2));
    send_key(k);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == KEY_LEFT || b == KEY_RIGHT || b == KEY_DELETE || b == KEY_NEWLINE);
    return b;
  endfunction

  task automatic type_line(input int n_keys);
    int r;
    for (int i = 0; i < n_keys; i++) begin
      r = $urandom_range(99);
      if (r < 50) key_with_gaps(text_byte());
      else if (r < 65) key_with_gaps(KEY_LEFT);
      else if (r < 80) key_with_gaps(KEY_RIGHT);
      else key_with_gaps(KEY_DELETE);
    end
    key_with_gaps(KEY_NEWLINE);
  endtask

  // fill to capacity, push extra bytes that get dropped; optionally delete
  // everything so the line ends empty but flagged
  task automatic fill_line(input bit delete_all);
    for (int i = 0; i < LINE_CAPACITY; i++) begin
      key_with_gaps(text_byte());
      if (!delete_all && $urandom_range(7) == 0)
        key_with_gaps($urandom_range(1) ? KEY_LEFT : KEY_RIGHT);
    end
    repeat ($urandom_range(1, 4)) key_with_gaps(text_byte());
    if (delete_all) begin
      repeat (LINE_CAPACITY) key_with_gaps(KEY_DELETE);
    end else begin
      key_with_gaps(KEY_LEFT);
      key_with_gaps(text_byte());
    end
    key_with_gaps(KEY_NEWLINE);
  endtask

  initial begin
    int r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_KEYS[i]) send_key(DIRECTED_KEYS[i]);
    wait_drained();

    fill_line(1'b0);
    fill_line(1'b1);
    wait_drained();

    while (keys_sent < RANDOM_STOP) begin
      r = $urandom_range(99);
      if (r < 4) fill_line(1'b0);
      else if (r < 20) repeat ($urandom_range(1, 12)) key_with_gaps(8'($urandom_range(255)));
      else type_line($urandom_range(1, 20));
      if ($urandom_range(99) < 5) wait_drained();
    end

    wait_drained();
    repeat (2 * LINE_CAPACITY + 8) @(posedge clk);

    $display("%0d keystrokes, %0d lines finished (%0d overflowed, %0d empty)",
             keys_sent, tracker.lines_done, tracker.ovf_lines, tracker.empty_lines);
    $display("%0d line characters checked", tracker.chars_checked);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
